FILE: rtl/pse_pkg.sv
// ----------------------------------------------------------------------------
// pse_pkg: shared types and constants of the role election unit
// Command, role, message and result codes, the configuration set, the
// registered input item and the result record.
// ----------------------------------------------------------------------------
package pse_pkg;

  // Magic word that every valid received message carries
  localparam logic [15:0] MAGIC_WORD = 16'hBEA7;

  // Result slots one item can produce and the width of their count
  localparam int RES_SLOTS = 3;
  localparam int CNT_W     = 2;

  // Width of the configuration index and data
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_LOCAL_PRIORITY     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LOCAL_IP           = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT_SECONDS    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_HEARTBEAT_INTERVAL = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ELECTION_WAIT      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_ELECTION_WINDOW    = 3'd5;

  // Input commands
  typedef enum logic [1:0] {
    CMD_TICK  = 2'd0,
    CMD_MSG   = 2'd1,
    CMD_START = 2'd2,
    CMD_STOP  = 2'd3
  } cmd_e;

  // Roles (also used as the start role; any other start code elects)
  localparam logic [1:0] ROLE_UNKNOWN = 2'd0;
  localparam logic [1:0] ROLE_PRIMARY = 2'd1;
  localparam logic [1:0] ROLE_STANDBY = 2'd2;

  // Message types
  localparam logic [1:0] MSG_NONE      = 2'd0;
  localparam logic [1:0] MSG_ANNOUNCE  = 2'd1;
  localparam logic [1:0] MSG_HEARTBEAT = 2'd2;
  localparam logic [1:0] MSG_DECLARE   = 2'd3;

  // Result kinds
  localparam logic [1:0] KIND_SEND   = 2'd0;
  localparam logic [1:0] KIND_NOTICE = 2'd1;
  localparam logic [1:0] KIND_STATUS = 2'd2;

  typedef struct packed {
    logic [15:0] local_priority;
    logic [31:0] local_ip;
    logic [15:0] timeout_seconds;
    logic [15:0] heartbeat_interval;
    logic [7:0]  election_wait;
    logic [7:0]  election_window;
  } cfg_t;

  typedef struct packed {
    cmd_e        command;
    logic [15:0] msg_magic;
    logic [1:0]  msg_type;
    logic [1:0]  msg_role;
    logic [15:0] msg_priority;
    logic [31:0] sender_ip;
    logic [1:0]  initial_role;
  } item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [1:0]  send_type;
    logic [1:0]  send_role;
    logic [31:0] send_sequence;
    logic [1:0]  old_role;
    logic [1:0]  new_role;
    logic [1:0]  role_now;
    logic        last;
  } result_t;

endpackage

FILE: rtl/primary_standby_role_election_unit.sv
// ----------------------------------------------------------------------------
// primary_standby_role_election_unit: primary/standby failover controller
// Top level with the input register, configuration registers, the election
// core and a three-entry result buffer.
// ----------------------------------------------------------------------------
// Usage:
//  Input channel (in_valid_i / in_stall_o) carries one request: a one-second
//  tick, a received message, a start or a stop. Output channel
//  (out_valid_o / out_stall_i) returns one to three results per request: an
//  optional message to send, an optional role change notice and a closing
//  status with last_o set. Configuration is a plain write port (cfg_we_i,
//  cfg_index_i, cfg_data_i); the user must write it only while the unit is
//  idle; the block does not enforce this. A request accepted into the input
//  register is stepped once the result buffer is free, and its first result
//  shows on the output right after that step. Each request gives 1 to 3
//  results; the single output port drains one buffered result per cycle
//  while out_stall_i is low, and status-only requests then flow at one per
//  cycle. The next request is taken into the input register while results
//  drain. Reset clears the role (unknown), the active flag, all timers,
//  counters and configuration to their defaults. A stalled receiver holds
//  the current result; the input register then fills and in_stall_o rises.
// ----------------------------------------------------------------------------
module primary_standby_role_election_unit #(
  parameter int AGE_WIDTH = 16
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // Configuration
  input  logic                               cfg_we_i,
  input  logic [pse_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [pse_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  // Input channel
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic [1:0]                         command_i,
  input  logic [15:0]                        msg_magic_i,
  input  logic [1:0]                         msg_type_i,
  input  logic [1:0]                         msg_role_i,
  input  logic [15:0]                        msg_priority_i,
  input  logic [31:0]                        sender_ip_i,
  input  logic [1:0]                         initial_role_i,
  // Output channel
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic [1:0]                         kind_o,
  output logic [1:0]                         send_type_o,
  output logic [1:0]                         send_role_o,
  output logic [31:0]                        send_sequence_o,
  output logic [1:0]                         old_role_o,
  output logic [1:0]                         new_role_o,
  output logic [1:0]                         role_now_o,
  output logic                               last_o
);
  import pse_pkg::*;

  cfg_t                          cfg_q;
  item_t                         item_q;
  logic                          in_valid_q;
  result_t [RES_SLOTS-1:0]       buf_q;
  result_t [RES_SLOTS-1:0]       res;
  logic [CNT_W-1:0]              res_cnt;
  logic [CNT_W-1:0]              cnt_q;
  logic [CNT_W-1:0]              rd_q;
  logic                          in_accept, pop, buf_free, step;
  result_t                       head;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.local_priority     <= 16'd0;
      cfg_q.local_ip           <= 32'd0;
      cfg_q.timeout_seconds    <= 16'd3;
      cfg_q.heartbeat_interval <= 16'd1;
      cfg_q.election_wait      <= 8'd2;
      cfg_q.election_window    <= 8'd5;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_LOCAL_PRIORITY:     cfg_q.local_priority     <= cfg_data_i[15:0];
        REG_LOCAL_IP:           cfg_q.local_ip           <= cfg_data_i;
        REG_TIMEOUT_SECONDS:    cfg_q.timeout_seconds    <= cfg_data_i[15:0];
        REG_HEARTBEAT_INTERVAL: cfg_q.heartbeat_interval <= cfg_data_i[15:0];
        REG_ELECTION_WAIT:      cfg_q.election_wait      <= cfg_data_i[7:0];
        REG_ELECTION_WINDOW:    cfg_q.election_window    <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  // Handshake: step when the buffer is empty or empties this cycle
  assign out_valid_o = (cnt_q != '0);
  assign pop         = out_valid_o && !out_stall_i;
  assign buf_free    = (cnt_q == '0) || (pop && (cnt_q == CNT_W'(1)));
  assign step        = in_valid_q && buf_free;
  assign in_stall_o  = in_valid_q && !buf_free;
  assign in_accept   = in_valid_i && !in_stall_o;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_accept || (in_valid_q && !step);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_q <= '0;
    end else if (in_accept) begin
      item_q.command      <= cmd_e'(command_i);
      item_q.msg_magic    <= msg_magic_i;
      item_q.msg_type     <= msg_type_i;
      item_q.msg_role     <= msg_role_i;
      item_q.msg_priority <= msg_priority_i;
      item_q.sender_ip    <= sender_ip_i;
      item_q.initial_role <= initial_role_i;
    end
  end

  pse_core #(
    .AGE_WIDTH (AGE_WIDTH)
  ) u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .item_valid_i (step),
    .item_i       (item_q),
    .res_o        (res),
    .res_cnt_o    (res_cnt)
  );

  // Result buffer: load on step, advance on pop
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      rd_q  <= '0;
    end else if (step) begin
      cnt_q <= res_cnt;
      rd_q  <= '0;
    end else if (pop) begin
      cnt_q <= cnt_q - CNT_W'(1);
      rd_q  <= rd_q + CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      buf_q <= res;
    end
  end

  // Drive the head result
  assign head            = buf_q[rd_q];
  assign kind_o          = head.kind;
  assign send_type_o     = head.send_type;
  assign send_role_o     = head.send_role;
  assign send_sequence_o = head.send_sequence;
  assign old_role_o      = head.old_role;
  assign new_role_o      = head.new_role;
  assign role_now_o      = head.role_now;
  assign last_o          = head.last;

  // A stepped request always leaves a result pending
  a_step_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step |=> out_valid_o)
    else $error("stepped request left the buffer empty");

  // The closing status is exactly the final buffered entry
  a_last_final: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (last_o == (cnt_q == CNT_W'(1))))
    else $error("last flag out of place");

  // Read pointer stays inside the buffer
  a_rd_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (({1'b0, rd_q} + {1'b0, cnt_q}) <= 3'(RES_SLOTS)))
    else $error("result buffer pointer overrun");

endmodule

FILE: rtl/pse_core.sv
// ----------------------------------------------------------------------------
// pse_core: role election state and single-pass item step
// Holds the election state and, for each request it is handed, works out the
// next state and up to three result records combinationally.
// ----------------------------------------------------------------------------
module pse_core #(
  parameter int AGE_WIDTH = 16
) (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  input  pse_pkg::cfg_t                            cfg_i,
  input  logic                                     item_valid_i,
  input  pse_pkg::item_t                           item_i,
  output pse_pkg::result_t [pse_pkg::RES_SLOTS-1:0] res_o,
  output logic [pse_pkg::CNT_W-1:0]                res_cnt_o
);
  import pse_pkg::*;

  // Compare width that holds the age and every configured limit
  localparam int CmpW = 33;

  logic [1:0]           role_q, role_d;
  logic                 active_q, active_d;
  logic [AGE_WIDTH-1:0] age_q, age_d, age_inc;
  logic                 seen_q, seen_d;
  logic [15:0]          send_cd_q, send_cd_d;
  logic [31:0]          seq_q, seq_d;
  logic [7:0]           elect_cd_q, elect_cd_d;
  logic                 electing_q, electing_d;

  logic                 has_msg, has_notice;
  logic [1:0]           msg_type, msg_role;
  logic                 sw_req;
  logic [1:0]           sw_role;
  logic                 magic_ok, not_self, yield;
  result_t              msg_rec, notice_rec, status_rec;

  // Received message checks
  assign magic_ok = (item_i.msg_magic == MAGIC_WORD);
  assign not_self = (item_i.sender_ip != cfg_i.local_ip);
  assign yield    = (item_i.msg_priority > cfg_i.local_priority) ||
                    ((item_i.msg_priority == cfg_i.local_priority) &&
                     (item_i.sender_ip < cfg_i.local_ip));

  // Saturating heartbeat age after a tick
  assign age_inc = (seen_q && (age_q != {AGE_WIDTH{1'b1}})) ?
                   age_q + AGE_WIDTH'(1) : age_q;

  // Step one item
  always_comb begin
    role_d     = role_q;
    active_d   = active_q;
    age_d      = age_q;
    seen_d     = seen_q;
    send_cd_d  = send_cd_q;
    elect_cd_d = elect_cd_q;
    electing_d = electing_q;
    has_msg    = 1'b0;
    has_notice = 1'b0;
    msg_type   = MSG_NONE;
    msg_role   = ROLE_UNKNOWN;
    sw_req     = 1'b0;
    sw_role    = ROLE_PRIMARY;

    unique case (item_i.command)
      CMD_START: begin
        if (!active_q) begin
          active_d   = 1'b1;
          electing_d = 1'b0;
          elect_cd_d = 8'd0;
          if (item_i.initial_role == ROLE_PRIMARY) begin
            role_d    = ROLE_PRIMARY;
            has_msg   = 1'b1;
            msg_type  = MSG_HEARTBEAT;
            msg_role  = ROLE_PRIMARY;
            send_cd_d = cfg_i.heartbeat_interval;
          end else if (item_i.initial_role == ROLE_STANDBY) begin
            role_d = ROLE_STANDBY;
          end else begin
            role_d     = ROLE_UNKNOWN;
            has_msg    = 1'b1;
            msg_type   = MSG_ANNOUNCE;
            msg_role   = ROLE_UNKNOWN;
            electing_d = 1'b1;
            elect_cd_d = cfg_i.election_wait;
          end
        end
      end
      CMD_STOP: begin
        active_d   = 1'b0;
        electing_d = 1'b0;
        elect_cd_d = 8'd0;
      end
      CMD_TICK: begin
        if (active_q) begin
          age_d = age_inc;
          if (electing_q) begin
            if (elect_cd_q > 8'd1) begin
              elect_cd_d = elect_cd_q - 8'd1;
            end else begin
              elect_cd_d = 8'd0;
              electing_d = 1'b0;
              sw_req     = 1'b1;
              sw_role    = (seen_q && (CmpW'(age_inc) < CmpW'(cfg_i.election_window))) ?
                           ROLE_STANDBY : ROLE_PRIMARY;
            end
          end else begin
            // Heartbeat schedule while primary
            if (role_q == ROLE_PRIMARY) begin
              if (send_cd_q <= 16'd1) begin
                has_msg   = 1'b1;
                msg_type  = MSG_HEARTBEAT;
                msg_role  = ROLE_PRIMARY;
                send_cd_d = cfg_i.heartbeat_interval;
              end else begin
                send_cd_d = send_cd_q - 16'd1;
              end
            end
            // Takeover once the primary has gone quiet
            if ((role_q == ROLE_STANDBY) &&
                (!seen_q || (CmpW'(age_inc) > CmpW'(cfg_i.timeout_seconds)))) begin
              sw_req  = 1'b1;
              sw_role = ROLE_PRIMARY;
            end
          end
        end
      end
      CMD_MSG: begin
        if (active_q && magic_ok) begin
          if ((item_i.msg_type == MSG_HEARTBEAT) && (item_i.msg_role == ROLE_PRIMARY)) begin
            age_d  = '0;
            seen_d = 1'b1;
            if ((role_q == ROLE_PRIMARY) && not_self && yield) begin
              sw_req  = 1'b1;
              sw_role = ROLE_STANDBY;
            end
          end else if (item_i.msg_type == MSG_ANNOUNCE) begin
            if (role_q == ROLE_PRIMARY) begin
              has_msg  = 1'b1;
              msg_type = MSG_DECLARE;
              msg_role = ROLE_PRIMARY;
            end
          end else if (item_i.msg_type == MSG_DECLARE) begin
            if ((item_i.msg_role == ROLE_PRIMARY) && (role_q == ROLE_PRIMARY) &&
                not_self && yield) begin
              sw_req  = 1'b1;
              sw_role = ROLE_STANDBY;
            end
          end
        end
      end
    endcase

    // Role change: declaration then notice
    if (sw_req && (sw_role != role_q)) begin
      role_d     = sw_role;
      has_msg    = 1'b1;
      msg_type   = MSG_DECLARE;
      msg_role   = sw_role;
      has_notice = 1'b1;
      if (sw_role == ROLE_PRIMARY) begin
        send_cd_d = 16'd1;
      end
    end
  end

  assign seq_d = seq_q + {31'b0, has_msg};

  // Build the result records
  always_comb begin
    msg_rec               = '0;
    msg_rec.kind          = KIND_SEND;
    msg_rec.send_type     = msg_type;
    msg_rec.send_role     = msg_role;
    msg_rec.send_sequence = seq_q;
    msg_rec.role_now      = role_d;

    notice_rec          = '0;
    notice_rec.kind     = KIND_NOTICE;
    notice_rec.old_role = role_q;
    notice_rec.new_role = role_d;
    notice_rec.role_now = role_d;

    status_rec          = '0;
    status_rec.kind     = KIND_STATUS;
    status_rec.role_now = role_d;
    status_rec.last     = 1'b1;

    res_o = {RES_SLOTS{status_rec}};
    if (has_msg) begin
      res_o[0] = msg_rec;
      res_o[1] = has_notice ? notice_rec : status_rec;
    end
  end

  assign res_cnt_o = CNT_W'(1) + CNT_W'(has_msg) + CNT_W'(has_notice);

  // Advance the state on each stepped item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      role_q     <= ROLE_UNKNOWN;
      active_q   <= 1'b0;
      age_q      <= '0;
      seen_q     <= 1'b0;
      send_cd_q  <= 16'd0;
      seq_q      <= 32'd0;
      elect_cd_q <= 8'd0;
      electing_q <= 1'b0;
    end else if (item_valid_i) begin
      role_q     <= role_d;
      active_q   <= active_d;
      age_q      <= age_d;
      seen_q     <= seen_d;
      send_cd_q  <= send_cd_d;
      seq_q      <= seq_d;
      elect_cd_q <= elect_cd_d;
      electing_q <= electing_d;
    end
  end

  // A notice always follows a declaration
  a_notice_has_msg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    has_notice |-> has_msg)
    else $error("role notice without declaration");

  // An election only runs from the unknown role
  a_elect_unknown: assert property (@(posedge clk_i) disable iff (!rst_ni)
    electing_q |-> (role_q == ROLE_UNKNOWN))
    else $error("election running with a settled role");

  // Role and sequence hold between items
  a_hold_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !item_valid_i |=> ($stable(role_q) && $stable(seq_q)))
    else $error("state moved without an item");

endmodule

FILE: bench/testbench.sv
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the primary/standby role election unit
// Drives ticks, received messages, starts and stops through the input
// channel with random gaps. Every result is checked against an in-bench
// model of the election logic or, for typed rows, a fixed status, in a short
// directed sequence and randomized phases under different register settings.
// ----------------------------------------------------------------------------
module testbench;
  import pse_pkg::*;

  localparam int AGE_W      = 16;
  localparam int PART_B_ROW = 17;
  localparam int PHASES     = 7;
  localparam int PHASE_REQS = 30;

  typedef struct packed {
    item_t      req;
    logic       typed;
    logic [1:0] exp_role;
  } plan_row_t;

  // Clock, reset and all block inputs, known from time zero
  logic                  clk_i       = 1'b0;
  logic                  rst_ni      = 1'b0;
  logic                  cfg_we      = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index   = '0;
  logic [CFG_DATA_W-1:0] cfg_data    = '0;
  logic                  in_valid    = 1'b0;
  logic [1:0]            command     = '0;
  logic [15:0]           msg_magic   = '0;
  logic [1:0]            msg_type    = '0;
  logic [1:0]            msg_role    = '0;
  logic [15:0]           msg_priority = '0;
  logic [31:0]           sender_ip   = '0;
  logic [1:0]            initial_role = '0;
  logic                  out_stall   = 1'b0;

  logic        in_stall_o;
  logic        out_valid_o;
  logic [1:0]  kind_o;
  logic [1:0]  send_type_o;
  logic [1:0]  send_role_o;
  logic [31:0] send_sequence_o;
  logic [1:0]  old_role_o;
  logic [1:0]  new_role_o;
  logic [1:0]  role_now_o;
  logic        last_o;

  // Election model state and its copy of the registers
  cfg_t             cfg_model;
  logic [1:0]       role_q;
  logic             running;
  logic [AGE_W-1:0] hb_age;
  logic             hb_seen;
  logic [15:0]      beat_cd;
  logic [31:0]      seq_q;
  logic [7:0]       vote_cd;
  logic             voting;

  result_t   step_results[$];
  result_t   expected_results[$];
  plan_row_t plan_rows[$];

  bit req_held   = 1'b0;
  bit idle_on    = 1'b1;
  int stall_left = 0;
  int fail_count = 0;

  primary_standby_role_election_unit #(.AGE_WIDTH(AGE_W)) uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data),
    .in_valid_i      (in_valid),
    .in_stall_o      (in_stall_o),
    .command_i       (command),
    .msg_magic_i     (msg_magic),
    .msg_type_i      (msg_type),
    .msg_role_i      (msg_role),
    .msg_priority_i  (msg_priority),
    .sender_ip_i     (sender_ip),
    .initial_role_i  (initial_role),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall),
    .kind_o          (kind_o),
    .send_type_o     (send_type_o),
    .send_role_o     (send_role_o),
    .send_sequence_o (send_sequence_o),
    .old_role_o      (old_role_o),
    .new_role_o      (new_role_o),
    .role_now_o      (role_now_o),
    .last_o          (last_o)
  );

  always #6 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Election model
  // ---------------------------------------------------------------------------

  // Queue an outgoing message; every one takes the next sequence number
  function automatic void push_send(input logic [1:0] mtype, input logic [1:0] mrole);
    result_t r;
    r = '0;
    r.kind          = KIND_SEND;
    r.send_type     = mtype;
    r.send_role     = mrole;
    r.send_sequence = seq_q;
    step_results.push_back(r);
    seq_q = seq_q + 32'd1;
  endfunction

  // Switch role: declaration carrying the new role, then the notice
  function automatic void change_role(input logic [1:0] nr);
    result_t r;
    if (role_q != nr) begin
      r = '0;
      r.kind     = KIND_NOTICE;
      r.old_role = role_q;
      r.new_role = nr;
      role_q = nr;
      push_send(MSG_DECLARE, nr);
      step_results.push_back(r);
      if (nr == ROLE_PRIMARY) beat_cd = 16'd1;
    end
  endfunction

  // Another primary wins on higher priority, or equal priority and lower IP
  function automatic bit outranked(input logic [15:0] prio, input logic [31:0] ip);
    return (prio > cfg_model.local_priority) ||
           (prio == cfg_model.local_priority && ip < cfg_model.local_ip);
  endfunction

  function automatic void model_tick();
    if (hb_seen && hb_age != {AGE_W{1'b1}}) hb_age = hb_age + 1'b1;
    if (voting) begin
      if (vote_cd > 8'd1) begin
        vote_cd = vote_cd - 8'd1;
      end else begin
        vote_cd = '0;
        voting  = 1'b0;
        if (hb_seen && hb_age < AGE_W'(cfg_model.election_window)) change_role(ROLE_STANDBY);
        else change_role(ROLE_PRIMARY);
      end
    end else begin
      if (role_q == ROLE_PRIMARY) begin
        if (beat_cd <= 16'd1) begin
          push_send(MSG_HEARTBEAT, ROLE_PRIMARY);
          beat_cd = cfg_model.heartbeat_interval;
        end else begin
          beat_cd = beat_cd - 16'd1;
        end
      end
      if (role_q == ROLE_STANDBY &&
          (!hb_seen || hb_age > AGE_W'(cfg_model.timeout_seconds)))
        change_role(ROLE_PRIMARY);
    end
  endfunction

  function automatic void model_message(input item_t req);
    bool_dummy: begin end
    if (req.msg_magic == MAGIC_WORD) begin
      if (req.msg_type == MSG_HEARTBEAT && req.msg_role == ROLE_PRIMARY) begin
        hb_age  = '0;
        hb_seen = 1'b1;
        if (role_q == ROLE_PRIMARY && req.sender_ip != cfg_model.local_ip &&
            outranked(req.msg_priority, req.sender_ip))
          change_role(ROLE_STANDBY);
      end else if (req.msg_type == MSG_ANNOUNCE) begin
        if (role_q == ROLE_PRIMARY) push_send(MSG_DECLARE, ROLE_PRIMARY);
      end else if (req.msg_type == MSG_DECLARE) begin
        if (req.msg_role == ROLE_PRIMARY && role_q == ROLE_PRIMARY &&
            req.sender_ip != cfg_model.local_ip &&
            outranked(req.msg_priority, req.sender_ip))
          change_role(ROLE_STANDBY);
      end
    end
  endfunction

  // Work out every result of one request into step_results
  function automatic void predict_request(input item_t req);
    result_t r;
    step_results.delete();
    case (req.command)
      CMD_START: begin
        if (!running) begin
          running = 1'b1;
          voting  = 1'b0;
          vote_cd = '0;
          if (req.initial_role == ROLE_PRIMARY) begin
            role_q = ROLE_PRIMARY;
            push_send(MSG_HEARTBEAT, ROLE_PRIMARY);
            beat_cd = cfg_model.heartbeat_interval;
          end else if (req.initial_role == ROLE_STANDBY) begin
            role_q = ROLE_STANDBY;
          end else begin
            role_q = ROLE_UNKNOWN;
            push_send(MSG_ANNOUNCE, ROLE_UNKNOWN);
            voting  = 1'b1;
            vote_cd = cfg_model.election_wait;
          end
        end
      end
      CMD_STOP: begin
        running = 1'b0;
        voting  = 1'b0;
        vote_cd = '0;
      end
      CMD_TICK: if (running) model_tick();
      default:  if (running) model_message(req);
    endcase
    r = '0;
    r.kind = KIND_STATUS;
    step_results.push_back(r);
    // Stamp the final role on every result and close the request
    foreach (step_results[k]) step_results[k].role_now = role_q;
    step_results[step_results.size()-1].last = 1'b1;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic item_t make_req(input cmd_e cmd, input logic [15:0] magic,
                                     input logic [1:0] mtype, input logic [1:0] mrole,
                                     input logic [15:0] prio, input logic [31:0] ip,
                                     input logic [1:0] init);
    item_t r;
    r.command      = cmd;
    r.msg_magic    = magic;
    r.msg_type     = mtype;
    r.msg_role     = mrole;
    r.msg_priority = prio;
    r.sender_ip    = ip;
    r.initial_role = init;
    return r;
  endfunction

  // Random request, mostly well-formed traffic around the local settings
  function automatic item_t random_request(input int beat_pct);
    item_t r;
    int    pick;
    r.command      = CMD_TICK;
    r.msg_magic    = 16'($urandom);
    r.msg_type     = 2'($urandom);
    r.msg_role     = 2'($urandom_range(0, 2));
    r.msg_priority = 16'($urandom);
    r.sender_ip    = $urandom;
    r.initial_role = 2'($urandom);
    pick = $urandom_range(0, 99);
    if (!running && pick < 60) begin
      r.command = CMD_START;
      return r;
    end
    if (pick < 3) begin
      r.command = CMD_STOP;
    end else if (pick < 5) begin
      r.command = CMD_START;
    end else if (pick < 50) begin
      r.command = CMD_TICK;
    end else begin
      r.command = CMD_MSG;
      if ($urandom_range(0, 9) != 0) r.msg_magic = MAGIC_WORD;
      if ($urandom_range(0, 99) < beat_pct) begin
        r.msg_type = MSG_HEARTBEAT;
        if ($urandom_range(0, 5) != 0) r.msg_role = ROLE_PRIMARY;
      end else begin
        case ($urandom_range(0, 4))
          0, 1:    r.msg_type = MSG_DECLARE;
          2, 3:    r.msg_type = MSG_ANNOUNCE;
          default: ;
        endcase
        if ($urandom_range(0, 3) != 0) r.msg_role = ROLE_PRIMARY;
      end
      case ($urandom_range(0, 5))
        0: r.msg_priority = cfg_model.local_priority;
        1: r.msg_priority = cfg_model.local_priority + 16'd1;
        2: r.msg_priority = cfg_model.local_priority - 16'd1;
        3: r.msg_priority = 16'h0000;
        4: r.msg_priority = 16'hFFFF;
        default: ;
      endcase
      case ($urandom_range(0, 5))
        0: r.sender_ip = cfg_model.local_ip;
        1: r.sender_ip = cfg_model.local_ip + 32'd1;
        2: r.sender_ip = cfg_model.local_ip - 32'd1;
        3: r.sender_ip = 32'h0000_0000;
        4: r.sender_ip = 32'hFFFF_FFFF;
        default: ;
      endcase
    end
    return r;
  endfunction

  // Present one request, hold it until taken, then record what it must give
  task automatic drive_request(input item_t req, input bit typed,
                               input logic [1:0] exp_role);
    int      gap;
    result_t st;
    gap = idle_on ? $urandom_range(0, 7) : 0;
    if (gap > 0) begin
      if (req_held) in_valid <= 1'b0;
      req_held = 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid     <= 1'b1;
    command      <= req.command;
    msg_magic    <= req.msg_magic;
    msg_type     <= req.msg_type;
    msg_role     <= req.msg_role;
    msg_priority <= req.msg_priority;
    sender_ip    <= req.sender_ip;
    initial_role <= req.initial_role;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    req_held = 1'b1;
    predict_request(req);
    if (typed) begin
      st = '0;
      st.kind     = KIND_STATUS;
      st.role_now = exp_role;
      st.last     = 1'b1;
      expected_results.push_back(st);
    end else begin
      foreach (step_results[k]) expected_results.push_back(step_results[k]);
    end
  endtask

  // Drop valid and wait until the block has nothing left to deliver
  task automatic settle();
    if (req_held) in_valid <= 1'b0;
    req_held = 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_config(input cfg_t c);
    cfg_we <= 1'b1;
    for (int i = 0; i < 6; i++) begin
      case (i)
        0: begin cfg_index <= REG_LOCAL_PRIORITY;     cfg_data <= 32'(c.local_priority); end
        1: begin cfg_index <= REG_LOCAL_IP;           cfg_data <= c.local_ip; end
        2: begin cfg_index <= REG_TIMEOUT_SECONDS;    cfg_data <= 32'(c.timeout_seconds); end
        3: begin cfg_index <= REG_HEARTBEAT_INTERVAL; cfg_data <= 32'(c.heartbeat_interval); end
        4: begin cfg_index <= REG_ELECTION_WAIT;      cfg_data <= 32'(c.election_wait); end
        default: begin
          cfg_index <= REG_ELECTION_WINDOW;
          cfg_data  <= 32'(c.election_window);
        end
      endcase
      @(posedge clk_i);
    end
    cfg_we <= 1'b0;
    cfg_model = c;
  endtask

  task automatic plan(input item_t req, input logic typed, input logic [1:0] exp_role);
    plan_row_t row;
    row.req      = req;
    row.typed    = typed;
    row.exp_role = exp_role;
    plan_rows.push_back(row);
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      fail_count++;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Result side: check each taken result, then stall for a random while
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin : result_side
    result_t want;
    int      hold;
    if (rst_ni) begin
      if (out_valid_o && !out_stall) begin
        if (expected_results.size() == 0) begin
          $error("unexpected result: kind %0h role_now %0h", kind_o, role_now_o);
          fail_count++;
        end else begin
          want = expected_results.pop_front();
          check_field("kind",          32'(want.kind),      32'(kind_o));
          check_field("send_type",     32'(want.send_type), 32'(send_type_o));
          check_field("send_role",     32'(want.send_role), 32'(send_role_o));
          check_field("send_sequence", want.send_sequence,  send_sequence_o);
          check_field("old_role",      32'(want.old_role),  32'(old_role_o));
          check_field("new_role",      32'(want.new_role),  32'(new_role_o));
          check_field("role_now",      32'(want.role_now),  32'(role_now_o));
          check_field("last",          32'(want.last),      32'(last_o));
        end
        hold = idle_on ? $urandom_range(0, 7) : 0;
        if (hold > 0) begin
          out_stall <= 1'b1;
          stall_left = hold;
        end
      end else if (out_stall) begin
        stall_left = stall_left - 1;
        if (stall_left <= 0) out_stall <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin : main_seq
    cfg_t c;
    int   beat_pct;
    // Model state after reset
    cfg_model = '{16'h0000, 32'h0000_0000, 16'd3, 16'd1, 8'd2, 8'd5};
    role_q  = ROLE_UNKNOWN;
    running = 1'b0;
    hb_age  = '0;
    hb_seen = 1'b0;
    beat_cd = '0;
    seq_q   = '0;
    vote_cd = '0;
    voting  = 1'b0;

    // Directed rows, first under the reset register values
    plan(make_req(CMD_TICK,  16'h0000, MSG_NONE, ROLE_UNKNOWN, 16'h0000, 32'h0, 2'd0),
         1'b1, ROLE_UNKNOWN);
    plan(make_req(CMD_MSG,   MAGIC_WORD, MSG_HEARTBEAT, ROLE_PRIMARY, 16'hFFFF, 32'h1, 2'd0),
         1'b1, ROLE_UNKNOWN);
    plan(make_req(CMD_STOP,  16'h0000, MSG_NONE, ROLE_UNKNOWN, 16'h0000, 32'h0, 2'd0),
         1'b1, ROLE_UNKNOWN);
    plan(make_req(CMD_START, 16'h0000, MSG_NONE, ROLE_UNKNOWN, 16'h0000, 32'h0, ROLE_PRIMARY),
         1'b0, ROLE_UNKNOWN);
    plan(make_req(CMD_START, 16'hFFFF, MSG_NONE, ROLE_UNKNOWN, 16'h0000, 32'h0, ROLE_STANDBY),
         1'b1, ROLE_PRIMARY);
    plan(make_req(CMD_MSG,   16'hBEA6, MSG_HEARTBEAT, ROLE_PRIMARY, 16'hFFFF, 32'h7, 2'd0),
         1'b1, ROLE_PRIMARY);
    plan(make_req(CMD_MSG,   MAGIC_WORD, MSG_NONE, ROLE_PRIMARY, 16'hFFFF, 32'h7, 2'd0),
         1'b1, ROLE_PRIMARY);
    plan(make_req(CMD_MSG,   MAGIC_WORD, MSG_ANNOUNCE, ROLE_UNKNOWN, 16'h0000, 32'h9, 2'd0),
         1'b0, ROLE_UNKNOWN);
    plan(make_req(CMD_TICK,  16'h0000, MSG_NONE, ROLE_UNKNOWN, 16'h0000, 32'h0, 2'd0),
         1'b0, ROLE_UNKNOWN);
    // Own address never makes the node yield
    plan(make_req(CMD_MSG,   MAGIC_WORD, MSG_HEARTBEAT, ROLE_PRIMARY, 16'hFFFF, 32'h0, 2'd0),
         1'b0, ROLE_UNKNOWN);
    plan(make_req(CMD_MSG,   MAGIC_WORD, MSG_DECLARE, ROLE_PRIMARY, 16'hFFFF,
                  32'hC0A8_0001, 2'd0), 1'b0, ROLE_UNKNOWN);
    // Standby ages out and takes over, then beats on the next tick
    repeat (5)
      plan(make_req(CMD_TICK, 16'h0000, MSG_NONE, ROLE_UNKNOWN, 16'h0000, 32'h0, 2'd0),
           1'b0, ROLE_UNKNOWN);
    plan(make_req(CMD_STOP,  16'h0000, MSG_NONE, ROLE_UNKNOWN, 16'h0000, 32'h0, 2'd0),
         1'b1, ROLE_PRIMARY);
    // Second part under the directed register set
    plan(make_req(CMD_START, 16'h0000, MSG_NONE, ROLE_UNKNOWN, 16'h0000, 32'h0, ROLE_UNKNOWN),
         1'b0, ROLE_UNKNOWN);
    plan(make_req(CMD_MSG,   MAGIC_WORD, MSG_HEARTBEAT, ROLE_PRIMARY, 16'h0000,
                  32'h0A00_0009, 2'd0), 1'b0, ROLE_UNKNOWN);
    repeat (2)
      plan(make_req(CMD_TICK, 16'h0000, MSG_NONE, ROLE_UNKNOWN, 16'h0000, 32'h0, 2'd0),
           1'b0, ROLE_UNKNOWN);
    plan(make_req(CMD_STOP,  16'h0000, MSG_NONE, ROLE_UNKNOWN, 16'h0000, 32'h0, 2'd0),
         1'b1, ROLE_STANDBY);
    plan(make_req(CMD_START, 16'h0000, MSG_NONE, ROLE_UNKNOWN, 16'h0000, 32'h0, ROLE_PRIMARY),
         1'b0, ROLE_UNKNOWN);
    // Equal priority, lower address wins the tie
    plan(make_req(CMD_MSG,   MAGIC_WORD, MSG_HEARTBEAT, ROLE_PRIMARY, 16'h1234,
                  32'h0A00_0001, 2'd0), 1'b0, ROLE_UNKNOWN);
    plan(make_req(CMD_STOP,  16'h0000, MSG_NONE, ROLE_UNKNOWN, 16'h0000, 32'h0, 2'd0),
         1'b1, ROLE_STANDBY);
    // Start role three runs an election
    plan(make_req(CMD_START, 16'h0000, MSG_NONE, ROLE_UNKNOWN, 16'h0000, 32'h0, 2'd3),
         1'b0, ROLE_UNKNOWN);

    // Hold reset, then release it
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Walk the directed rows
    idle_on = 1'b1;
    for (int i = 0; i < plan_rows.size(); i++) begin
      if (i == PART_B_ROW) begin
        settle();
        write_config('{16'h1234, 32'h0A00_0005, 16'd2, 16'd3, 8'd2, 8'd5});
      end
      drive_request(plan_rows[i].req, plan_rows[i].typed, plan_rows[i].exp_role);
    end

    // Random phases, one register setting each
    for (int ph = 0; ph < PHASES; ph++) begin
      settle();
      case (ph)
        0: c = '{16'h0000, 32'h0000_0000, 16'd1, 16'd1, 8'd1, 8'd1};
        1: c = '{16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 8'd255, 8'd255};
        default: begin
          c.local_priority     = ($urandom_range(0, 2) == 0) ? 16'hFFFF : 16'($urandom);
          c.local_ip           = $urandom;
          c.timeout_seconds    = 16'($urandom_range(1, 6));
          c.heartbeat_interval = 16'($urandom_range(1, 4));
          c.election_wait      = 8'($urandom_range(1, 4));
          c.election_window    = 8'($urandom_range(1, 8));
          // Zero interval and zero wait count as one
          if (ph == 2) begin
            c.heartbeat_interval = 16'd0;
            c.election_wait      = 8'd0;
          end
        end
      endcase
      write_config(c);
      beat_pct = $urandom_range(10, 70);
      for (int n = 0; n < PHASE_REQS; n++) begin
        if (n % 10 == 0) idle_on = ($urandom_range(0, 3) != 0);
        // Let the output run dry once mid-phase
        if (ph == 4 && n == 15) settle();
        if (n == 0)
          drive_request(make_req(CMD_STOP, 16'($urandom), 2'($urandom), 2'($urandom_range(0, 2)),
                                 16'($urandom), $urandom, 2'($urandom)), 1'b0, ROLE_UNKNOWN);
        else
          drive_request(random_request(beat_pct), 1'b0, ROLE_UNKNOWN);
      end
    end

    // Drain and report
    settle();
    repeat (8) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // Hard stop well past the slowest correct run
  initial begin : watchdog
    #(12 * 200000);
    $display("TB_ERROR");
    $finish;
  end

endmodule

FILE: files.f
rtl/pse_pkg.sv
rtl/pse_core.sv
rtl/primary_standby_role_election_unit.sv
bench/testbench.sv
